[hdl/polynomial_term_merge_add_top_defines.svh]
// Assertion macros for the term merge adder.
`ifndef POLYNOMIAL_TERM_MERGE_ADD_TOP_DEFINES_SVH
`define POLYNOMIAL_TERM_MERGE_ADD_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PTMA_ASSERT_SAME(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`define PTMA_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define PTMA_ASSERT_SAME(lbl, clk, rst, pre, post, msg)
`define PTMA_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif
`endif

[hdl/ptma_pkg.sv]
package ptma_pkg;

  localparam int MAX_TERMS_DEF = 16;

  localparam int KIND_W = 2;
  localparam int COEF_W = 16;
  localparam int SUM_W  = 17;
  localparam int EXP_W  = 8;

  localparam logic [KIND_W-1:0] KIND_INS_A = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INS_B = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [COEF_W-1:0] term_coef;
    logic [EXP_W-1:0]         term_exponent;
  } item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum_coef;
    logic [EXP_W-1:0]        sum_exponent;
    logic                    last_term;
    logic                    empty_result;
  } result_t;

  typedef struct packed {
    logic push_a;
    logic push_b;
    logic load;
    logic step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic last;
  } dp_stat_t;

endpackage

[hdl/ptma_stream_if.sv]
interface ptma_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[hdl/ptma_ctrl.sv]
module ptma_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ptma_pkg::KIND_W-1:0]  in_kind,
  input  ptma_pkg::dp_stat_t           stat,
  output ptma_pkg::ctrl_cmd_t          cmd
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_MERGE = 1'b1;

  logic state;
  logic state_next;
  logic accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_kind)
            ptma_pkg::KIND_INS_A: cmd.push_a = 1'b1;
            ptma_pkg::KIND_INS_B: cmd.push_b = 1'b1;
            ptma_pkg::KIND_ADD: begin
              cmd.load   = 1'b1;
              state_next = ST_MERGE;
            end
            default: ;
          endcase
        end
      end
      ST_MERGE: begin
        if (stat.out_free) begin
          cmd.step = 1'b1;
          if (stat.last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hdl/ptma_dp.sv]
`include "polynomial_term_merge_add_top_defines.svh"

module ptma_dp #(
  parameter int MAX_TERMS = ptma_pkg::MAX_TERMS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ptma_pkg::ctrl_cmd_t  cmd,
  input  ptma_pkg::item_t      item,
  output ptma_pkg::dp_stat_t   stat,
  output logic                 res_valid,
  input  logic                 res_ready,
  output ptma_pkg::result_t    res
);

  localparam int ADDR_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W  = $clog2(MAX_TERMS + 1);
  localparam int DEPTH  = 1 << ADDR_W;

  logic signed [ptma_pkg::COEF_W-1:0] coef_a [DEPTH];
  logic [ptma_pkg::EXP_W-1:0]         exp_a  [DEPTH];
  logic signed [ptma_pkg::COEF_W-1:0] coef_b [DEPTH];
  logic [ptma_pkg::EXP_W-1:0]         exp_b  [DEPTH];

  logic [CNT_W-1:0] cnt_a;
  logic [CNT_W-1:0] cnt_b;
  logic [CNT_W-1:0] ia;
  logic [CNT_W-1:0] ib;
  logic [CNT_W-1:0] ia_next;
  logic [CNT_W-1:0] ib_next;
  logic [CNT_W-1:0] ia_left;
  logic [CNT_W-1:0] ib_left;
  logic [CNT_W-1:0] ia_dec;
  logic [CNT_W-1:0] ib_dec;
  logic [ADDR_W-1:0] rd_a;
  logic [ADDR_W-1:0] rd_b;

  logic signed [ptma_pkg::COEF_W-1:0] head_coef_a;
  logic [ptma_pkg::EXP_W-1:0]         head_exp_a;
  logic signed [ptma_pkg::COEF_W-1:0] head_coef_b;
  logic [ptma_pkg::EXP_W-1:0]         head_exp_b;

  logic                               a_has;
  logic                               b_has;
  logic                               take_a;
  logic                               take_b;
  logic signed [ptma_pkg::SUM_W-1:0]  add_a;
  logic signed [ptma_pkg::SUM_W-1:0]  add_b;
  ptma_pkg::result_t                  res_next;

  assign a_has  = (ia != '0);
  assign b_has  = (ib != '0);
  assign take_a = a_has && (!b_has || (head_exp_a >= head_exp_b));
  assign take_b = b_has && (!a_has || (head_exp_b >= head_exp_a));

  assign ia_left = ia - CNT_W'(take_a);
  assign ib_left = ib - CNT_W'(take_b);

  assign stat.out_free = !res_valid || res_ready;
  assign stat.last     = (ia_left == '0) && (ib_left == '0);

  always_comb begin
    ia_next = ia;
    ib_next = ib;
    if (cmd.load) begin
      ia_next = cnt_a;
      ib_next = cnt_b;
    end else if (cmd.step) begin
      ia_next = ia_left;
      ib_next = ib_left;
    end
  end

  assign ia_dec = ia_next - CNT_W'(1);
  assign ib_dec = ib_next - CNT_W'(1);
  assign rd_a   = ia_dec[ADDR_W-1:0];
  assign rd_b   = ib_dec[ADDR_W-1:0];

  // one merge step: sum on equal exponents, otherwise the larger exponent
  assign add_a = take_a ? ptma_pkg::SUM_W'(head_coef_a) : '0;
  assign add_b = take_b ? ptma_pkg::SUM_W'(head_coef_b) : '0;

  always_comb begin
    res_next.sum_coef     = add_a + add_b;
    res_next.sum_exponent = take_a ? head_exp_a : (take_b ? head_exp_b : '0);
    res_next.last_term    = stat.last;
    res_next.empty_result = !a_has && !b_has;
  end

  always_ff @(posedge clk) begin
    if (cmd.push_a && (cnt_a < CNT_W'(MAX_TERMS))) begin
      coef_a[cnt_a[ADDR_W-1:0]] <= item.term_coef;
      exp_a[cnt_a[ADDR_W-1:0]]  <= item.term_exponent;
    end
    if (cmd.push_b && (cnt_b < CNT_W'(MAX_TERMS))) begin
      coef_b[cnt_b[ADDR_W-1:0]] <= item.term_coef;
      exp_b[cnt_b[ADDR_W-1:0]]  <= item.term_exponent;
    end
    head_coef_a <= coef_a[rd_a];
    head_exp_a  <= exp_a[rd_a];
    head_coef_b <= coef_b[rd_b];
    head_exp_b  <= exp_b[rd_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_a <= '0;
      cnt_b <= '0;
      ia    <= '0;
      ib    <= '0;
    end else begin
      if (cmd.push_a && (cnt_a < CNT_W'(MAX_TERMS))) begin
        cnt_a <= cnt_a + CNT_W'(1);
      end
      if (cmd.push_b && (cnt_b < CNT_W'(MAX_TERMS))) begin
        cnt_b <= cnt_b + CNT_W'(1);
      end
      ia <= ia_next;
      ib <= ib_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.step) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      res <= res_next;
    end
  end

  `PTMA_ASSERT_SAME(a_no_overwrite, clk, rst, res_valid && !res_ready, !cmd.step, "step over held result")
  `PTMA_ASSERT_NEXT(a_last_drains, clk, rst, cmd.step && stat.last, (ia == '0) && (ib == '0), "lists not drained after last term")
  `PTMA_ASSERT_NEXT(a_step_consumes, clk, rst, cmd.step && (a_has || b_has), ($past(ia) != ia) || ($past(ib) != ib), "merge step consumed no term")
  `PTMA_ASSERT_SAME(a_no_push_in_merge, clk, rst, cmd.step || cmd.load, !cmd.push_a && !cmd.push_b, "insert during add")

endmodule

[hdl/polynomial_term_merge_add_top.sv]
// Sparse polynomial adder by term merge.
// items (sink): kind 0 pushes (term_coef, term_exponent) onto list A, kind 1
//   onto list B, kind 2 starts an add; kind 3 is taken and dropped. A push
//   onto a full list (MAX_TERMS terms) is dropped.
// results (source): one transfer per merged term, most recent terms first,
//   highest exponent leading where the lists are ordered; last_term marks the
//   end of a run. An add with both lists empty gives a single transfer with
//   empty_result and last_term set and zero term fields.
// Items are taken back to back while no add is running.
// An add first loads both list heads into the head registers, then emits one
//   term per cycle from the list memories while results is not stalled; each
//   term passes the head registers and then the output register.
//   No item is taken until the last term of the run is in the output register.
// When results stalls, the term in the output register holds and the merge
//   waits; inserts are still taken while a finished term waits.
// Reset empties both lists and drops any held result; lists keep their
//   terms across adds.
module polynomial_term_merge_add_top #(
  parameter int MAX_TERMS = ptma_pkg::MAX_TERMS_DEF
) (
  input logic    clk,
  input logic    rst,
  ptma_stream_if.sink   items,
  ptma_stream_if.source results
);

  ptma_pkg::ctrl_cmd_t cmd;
  ptma_pkg::dp_stat_t  stat;

  ptma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (items.ready),
    .in_kind  (items.data.kind),
    .stat     (stat),
    .cmd      (cmd)
  );

  ptma_dp #(
    .MAX_TERMS (MAX_TERMS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .item      (items.data),
    .stat      (stat),
    .res_valid (results.valid),
    .res_ready (results.ready),
    .res       (results.data)
  );

endmodule
